// ===== rtl/fups_pkg.sv =====
// Package: types, character codes and the per-byte decode step for the param splitter.
`default_nettype none

package fups_pkg;

    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam int unsigned MAX_RES = 4;

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       value_present;
    } res_t;

    typedef struct packed {
        logic       in_value;
        logic [1:0] held_count;
        logic [7:0] held_digit;
        logic       name_nonempty;
        logic       field_truncated;
        logic       param_skipped;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]           count;
        res_t [MAX_RES-1:0]   res;
    } batch_t;

    typedef struct packed {
        parse_state_t st;
        batch_t       out;
    } work_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, b[3:0]};
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            r = {1'b1, b[3:0] + 4'd9};
        return r;
    endfunction

    function automatic work_t put_res(input work_t w, input logic [1:0] k,
                                      input logic [7:0] b, input logic vp);
        work_t r;
        r = w;
        if (r.out.count < 3'(MAX_RES))
        begin
            r.out.res[r.out.count[1:0]].kind          = k;
            r.out.res[r.out.count[1:0]].data          = b;
            r.out.res[r.out.count[1:0]].value_present = vp;
            r.out.count = r.out.count + 3'd1;
        end
        return r;
    endfunction

    function automatic work_t emit_data(input work_t w, input logic [7:0] b);
        work_t r;
        r = w;
        if (!r.st.field_truncated)
        begin
            if (b == 8'd0)
                r.st.field_truncated = 1'b1;
            else if (r.st.in_value)
            begin
                if (!r.st.param_skipped)
                    r = put_res(r, KIND_VALUE, b, 1'b0);
            end
            else
            begin
                r = put_res(r, KIND_NAME, b, 1'b0);
                r.st.name_nonempty = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic work_t decode_plain(input work_t w, input logic [7:0] b);
        work_t r;
        r = w;
        if (b == CHAR_PLUS)
            r = emit_data(r, CHAR_SPACE);
        else if (b == CHAR_PCT)
            r.st.held_count = HELD_PCT;
        else
            r = emit_data(r, b);
        return r;
    endfunction

    function automatic work_t feed(input work_t w, input logic [7:0] b);
        work_t      r;
        logic [4:0] hv;
        logic [4:0] hi;
        logic [7:0] d;
        r  = w;
        hv = hex_value(b);
        hi = hex_value(r.st.held_digit);
        d  = r.st.held_digit;
        if (r.st.held_count == HELD_PCT)
        begin
            if (hv[4])
            begin
                r.st.held_digit = b;
                r.st.held_count = HELD_DIGIT;
            end
            else
            begin
                r = emit_data(r, CHAR_PCT);
                r.st.held_count = HELD_NONE;
                r = decode_plain(r, b);
            end
        end
        else if (r.st.held_count == HELD_DIGIT)
        begin
            r.st.held_count = HELD_NONE;
            r.st.held_digit = 8'd0;
            if (hv[4])
                r = emit_data(r, {(hi[4] ? hi[3:0] : 4'd0), hv[3:0]});
            else
            begin
                r = emit_data(r, CHAR_PCT);
                r = emit_data(r, d);
                r = decode_plain(r, b);
            end
        end
        else
            r = decode_plain(r, b);
        return r;
    endfunction

    function automatic work_t flush_held(input work_t w);
        work_t r;
        r = w;
        if (r.st.held_count >= HELD_PCT)
            r = emit_data(r, CHAR_PCT);
        if (r.st.held_count >= HELD_DIGIT)
            r = emit_data(r, r.st.held_digit);
        r.st.held_count = HELD_NONE;
        r.st.held_digit = 8'd0;
        return r;
    endfunction

    function automatic work_t end_param(input work_t w);
        work_t r;
        r = flush_held(w);
        if (!r.st.param_skipped && r.st.name_nonempty)
            r = put_res(r, KIND_END, 8'd0, r.st.in_value);
        r.st.in_value        = 1'b0;
        r.st.name_nonempty   = 1'b0;
        r.st.field_truncated = 1'b0;
        r.st.param_skipped   = 1'b0;
        return r;
    endfunction

    function automatic work_t parse_step(input parse_state_t s, input logic [7:0] b,
                                         input logic last);
        work_t r;
        r     = '0;
        r.st  = s;
        if (b == CHAR_AMP)
            r = end_param(r);
        else if (b == CHAR_EQ && !r.st.in_value)
        begin
            r = flush_held(r);
            if (!r.st.name_nonempty)
                r.st.param_skipped = 1'b1;
            r.st.in_value        = 1'b1;
            r.st.field_truncated = 1'b0;
        end
        else
            r = feed(r, b);
        if (last)
            r = end_param(r);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fups_in_if.sv =====
// Interface: input byte channel of the param splitter.
`default_nettype none

interface fups_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       string_end;

    modport source (output valid, output char_byte, output string_end, input ready);
    modport sink   (input valid, input char_byte, input string_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/fups_out_if.sv =====
// Interface: result channel of the param splitter.
`default_nettype none

interface fups_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic       value_present;
    logic       run_last;

    modport source (output valid, output result_kind, output out_byte,
                    output value_present, output run_last, input ready);
    modport sink   (input valid, input result_kind, input out_byte,
                    input value_present, input run_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/fups_decode.sv =====
// Parse state registers and the combinational decode of one input byte.
`default_nettype none

module fups_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire logic [7:0]      char_byte,
    input  wire logic            string_end,
    output fups_pkg::batch_t     batch
);
    import fups_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    work_t        step;

    always_comb
    begin
        step       = parse_step(state_reg, char_byte, string_end);
        batch      = step.out;
        state_next = load ? step.st : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== rtl/fups_outq.sv =====
// Result buffer: holds the results of one byte and drains them one beat per cycle while results.ready is high.
`default_nettype none

module fups_outq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire fups_pkg::batch_t  batch,
    output logic                   can_load,
    output logic [2:0]             level,
    fups_out_if.source             results
);
    import fups_pkg::*;

    res_t [MAX_RES-1:0] res_reg;
    res_t [MAX_RES-1:0] res_next;
    logic [2:0]         cnt_reg;
    logic [2:0]         cnt_next;
    logic               pop;

    assign pop      = results.valid && results.ready;
    assign can_load = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && results.ready);
    assign level    = cnt_reg;

    assign results.valid         = (cnt_reg != 3'd0);
    assign results.result_kind   = res_reg[0].kind;
    assign results.out_byte      = res_reg[0].data;
    assign results.value_present = res_reg[0].value_present;
    assign results.run_last      = (cnt_reg == 3'd1);

    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            res_next = batch.res;
            cnt_next = batch.count;
        end
        else if (pop)
        begin
            // shift toward the head
            res_next = {res_t'('0), res_reg[MAX_RES-1:1]};
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

// ===== rtl/form_urlencoded_param_splitter.sv =====
// Top level: form-urlencoded parameter splitter.
//
//   channel   dir   payload                                          width
//   chars     in    char_byte, string_end                            8+1
//   results   out   result_kind, out_byte, value_present, run_last   2+8+1+1
//
// A byte is decoded in the cycle it is accepted; its 0..4 results land in the
// result buffer and leave on the results channel one beat per cycle while it
// is ready. A byte's results hold the buffer until all have left, so bytes
// giving one result or none flow at one per cycle while results are taken;
// the single result port sets the rate. A byte is taken while the last result
// leaves in the same cycle. Reset clears parse state and empties the buffer.
`default_nettype none

module form_urlencoded_param_splitter (
    input  wire logic    clk,
    input  wire logic    rst_n,
    fups_in_if.sink      chars,
    fups_out_if.source   results
);
    import fups_pkg::*;

    batch_t     batch;
    logic       can_load;
    logic       in_fire;
    logic [2:0] level;

    assign chars.ready = can_load;
    assign in_fire     = chars.valid && can_load;

    fups_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_fire),
        .char_byte  (chars.char_byte),
        .string_end (chars.string_end),
        .batch      (batch)
    );

    fups_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_fire),
        .batch    (batch),
        .can_load (can_load),
        .level    (level),
        .results  (results)
    );

    a_load_level: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> level == $past(batch.count))
        else $error("buffer level differs from result count of accepted byte");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.ready && level == 3'd1 && !in_fire |=> !results.valid)
        else $error("results still valid after last beat drained");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.result_kind == KIND_END |-> results.out_byte == 8'd0)
        else $error("end mark carries a nonzero byte");

    a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
        level <= 3'(MAX_RES))
        else $error("result buffer overfilled");

endmodule

`default_nettype wire

// ===== sim/form_urlencoded_param_splitter_checker.sv =====
`timescale 1ns / 1ps
// Checker: predicts the decoded result beats of the param splitter and compares them.
module form_urlencoded_param_splitter_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    fups_in_if        chars,
    fups_out_if       results,
    output int        errors,
    output int        pending
);
    import fups_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       vp;
        logic       last;
    } beat_t;

    beat_t decoded_q[$];
    beat_t step_q[$];

    // parser state
    logic       in_val;
    logic [1:0] esc_cnt;
    logic [7:0] esc_digit;
    logic       name_seen;
    logic       cut;
    logic       skip;

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
            return int'(b) - 8'h30;
        if (b >= 8'h61 && b <= 8'h66)
            return int'(b) - 8'h61 + 10;
        if (b >= 8'h41 && b <= 8'h46)
            return int'(b) - 8'h41 + 10;
        return -1;
    endfunction

    // adds one beat; at most MAX_RES beats per byte
    function automatic void put_beat(input logic [1:0] k, input logic [7:0] d,
                                     input logic vp);
        if (step_q.size() < MAX_RES)
            step_q.push_back(beat_t'{k, d, vp, 1'b0});
    endfunction

    function automatic void put_data(input logic [7:0] b);
        if (cut)
            return;
        if (b == 8'd0)
        begin
            cut = 1'b1;
            return;
        end
        if (in_val)
        begin
            if (!skip)
                put_beat(KIND_VALUE, b, 1'b0);
        end
        else
        begin
            put_beat(KIND_NAME, b, 1'b0);
            name_seen = 1'b1;
        end
    endfunction

    function automatic void take_plain(input logic [7:0] b);
        if (b == CHAR_PLUS)
            put_data(CHAR_SPACE);
        else if (b == CHAR_PCT)
            esc_cnt = HELD_PCT;
        else
            put_data(b);
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        int         lo;
        int         hi;
        logic [7:0] d;
        lo = hex_nibble(b);
        if (esc_cnt == HELD_PCT)
        begin
            if (lo >= 0)
            begin
                esc_digit = b;
                esc_cnt   = HELD_DIGIT;
            end
            else
            begin
                put_data(CHAR_PCT);
                esc_cnt = HELD_NONE;
                take_plain(b);
            end
        end
        else if (esc_cnt == HELD_DIGIT)
        begin
            hi        = hex_nibble(esc_digit);
            d         = esc_digit;
            esc_cnt   = HELD_NONE;
            esc_digit = 8'd0;
            if (lo >= 0)
                put_data(8'((hi < 0 ? 0 : hi) * 16 + lo));
            else
            begin
                put_data(CHAR_PCT);
                put_data(d);
                take_plain(b);
            end
        end
        else
            take_plain(b);
    endfunction

    // held '%' and digit go out as literal bytes
    function automatic void flush_escape();
        if (esc_cnt >= HELD_PCT)
            put_data(CHAR_PCT);
        if (esc_cnt >= HELD_DIGIT)
            put_data(esc_digit);
        esc_cnt   = HELD_NONE;
        esc_digit = 8'd0;
    endfunction

    function automatic void close_param();
        flush_escape();
        if (!skip && name_seen)
            put_beat(KIND_END, 8'd0, in_val);
        in_val    = 1'b0;
        name_seen = 1'b0;
        cut       = 1'b0;
        skip      = 1'b0;
    endfunction

    function automatic void split_byte(input logic [7:0] b, input logic last);
        step_q.delete();
        if (b == CHAR_AMP)
            close_param();
        else if (b == CHAR_EQ && !in_val)
        begin
            flush_escape();
            if (!name_seen)
                skip = 1'b1;
            in_val = 1'b1;
            cut    = 1'b0;
        end
        else
            take_byte(b);
        if (last)
            close_param();
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            decoded_q.push_back(step_q[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        beat_t want;
        if (!rst_n)
        begin
            in_val    = 1'b0;
            esc_cnt   = HELD_NONE;
            esc_digit = 8'd0;
            name_seen = 1'b0;
            cut       = 1'b0;
            skip      = 1'b0;
            decoded_q.delete();
            errors    = 0;
        end
        else
        begin
            // results of a byte are registered in the buffer before they leave, so order here is free
            if (chars.valid && chars.ready)
                split_byte(chars.char_byte, chars.string_end);
            if (results.valid && results.ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    errors++;
                    $error("unexpected result beat: result_kind %0d out_byte %02h",
                           results.result_kind, results.out_byte);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (results.result_kind !== want.kind)
                    begin
                        errors++;
                        $error("result_kind: expected %0d, got %0d",
                               want.kind, results.result_kind);
                    end
                    if (results.out_byte !== want.data)
                    begin
                        errors++;
                        $error("out_byte: expected %02h, got %02h",
                               want.data, results.out_byte);
                    end
                    if (results.value_present !== want.vp)
                    begin
                        errors++;
                        $error("value_present: expected %0d, got %0d",
                               want.vp, results.value_present);
                    end
                    if (results.run_last !== want.last)
                    begin
                        errors++;
                        $error("run_last: expected %0d, got %0d",
                               want.last, results.run_last);
                    end
                end
            end
        end
        pending = decoded_q.size();
    end

endmodule

// ===== sim/form_urlencoded_param_splitter_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives form-urlencoded strings into the splitter and gives the verdict.
module form_urlencoded_param_splitter_tb;
    import fups_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_BYTES = 200;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    bit   idle_on;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    int   sent = 0;

    // {string_end, char_byte}
    logic [8:0] str_q[$];

    fups_in_if  chars_if();
    fups_out_if results_if();

    form_urlencoded_param_splitter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    form_urlencoded_param_splitter_checker decode_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // result side back-pressure in bursts
    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            stall_left       = 0;
            results_if.ready = 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            results_if.ready = 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left       = $urandom_range(1, 14) - 1;
            results_if.ready = 1'b0;
        end
        else
            results_if.ready = 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (chars_if.valid && chars_if.ready)
            || (results_if.valid && results_if.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            chars_if.valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        chars_if.valid      = 1'b1;
        chars_if.char_byte  = b;
        chars_if.string_end = last;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_queued();
        logic [8:0] x;
        while (str_q.size() != 0)
        begin
            x = str_q.pop_front();
            send_beat(x[7:0], x[8]);
        end
    endtask

    task automatic push_raw(input logic [7:0] b, input logic last);
        str_q.push_back({last, b});
    endtask

    task automatic push_str(input string s, input bit end_it);
        for (int i = 0; i < s.len(); i++)
            push_raw(s[i], end_it && i == s.len() - 1);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return 8'h30 + n;
        return (upper ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic logic [7:0] plain_char();
        case ($urandom_range(0, 2))
            0:       return 8'($urandom_range(8'h61, 8'h7a));
            1:       return 8'($urandom_range(8'h41, 8'h5a));
            default: return 8'($urandom_range(8'h30, 8'h39));
        endcase
    endfunction

    task automatic add_tokens(input int n);
        int sel;
        repeat (n)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2, 3: push_raw(plain_char(), 1'b0);
                4:          push_raw(CHAR_PLUS, 1'b0);
                5, 6:
                begin
                    push_raw(CHAR_PCT, 1'b0);
                    push_raw(hex_char(4'($urandom), $urandom_range(0, 1)), 1'b0);
                    push_raw(hex_char(4'($urandom), $urandom_range(0, 1)), 1'b0);
                end
                7:
                begin
                    // broken escape
                    push_raw(CHAR_PCT, 1'b0);
                    if ($urandom_range(0, 1))
                        push_raw(hex_char(4'($urandom), $urandom_range(0, 1)), 1'b0);
                    case ($urandom_range(0, 2))
                        0:       push_raw(8'($urandom_range(8'h67, 8'h7a)), 1'b0);
                        1:       push_raw(CHAR_PLUS, 1'b0);
                        default: push_raw(CHAR_PCT, 1'b0);
                    endcase
                end
                8:          push_raw(8'($urandom_range(1, 255)), 1'b0);
                default:    push_str("%00", 1'b0);
            endcase
        end
    endtask

    task automatic make_param();
        int r;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
                push_raw(8'($urandom_range(1, 255)), 1'b0);
        end
        else
        begin
            add_tokens($urandom_range(0, 4));
            if ($urandom_range(0, 3) != 0)
            begin
                push_raw(CHAR_EQ, 1'b0);
                add_tokens($urandom_range(0, 5));
            end
        end
        r = $urandom_range(0, 9);
        if (r <= 5)
            push_raw(CHAR_AMP, 1'b0);
        else if (r == 6)
            push_raw(CHAR_AMP, 1'b1);
        else if (r == 7)
        begin
            push_raw(CHAR_AMP, 1'b0);
            push_raw(CHAR_AMP, 1'b0);
        end
        else if (str_q.size() != 0)
            str_q[str_q.size() - 1][8] = 1'b1;
        else
            push_raw(CHAR_AMP, 1'b1);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        idle_on             = 1'b1;
        chars_if.valid      = 1'b0;
        chars_if.char_byte  = 8'd0;
        chars_if.string_end = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // plus, flush at '=', upper and lower escapes, '%' then non-hex
        push_str("a+%4=%41%6a%z&", 1'b0);
        // empty name, empty segment
        push_str("=v&&", 1'b0);
        // zero byte leaves the name empty; held digit then non-hex; '%' flushed at end
        push_str("%00=%4g%", 1'b1);
        // extreme bytes; held digit flushed at '&' which also ends the string
        push_raw(8'hFF, 1'b0);
        push_raw(CHAR_EQ, 1'b0);
        push_raw(8'h01, 1'b0);
        push_str("%4&", 1'b1);
        send_queued();

        // hold off until the result side has drained
        chars_if.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            idle_on = !((sent >= 80 && sent < 110) || sent >= RANDOM_BYTES - 40);
            make_param();
            send_queued();
        end

        chars_if.valid = 1'b0;
        idle_on        = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
